[hdl/tcs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_pkg
// Shared widths, limits, register indexes and state codes for the tach
// capture speed block.
// ----------------------------------------------------------------------------
package tcs_pkg;

    // field and datapath widths
    localparam int TIMER_BITS   = 32;
    localparam int SPEED_BITS   = 24;
    localparam int CAPTURE_BITS = 32;
    localparam int SCALE_BITS   = 48;
    localparam int TOP_BITS     = 32;
    localparam int CNT_BITS     = $clog2(SCALE_BITS);

    // largest speed code, used when the quotient is clamped
    localparam logic [SPEED_BITS-1:0] SPEED_MAX = {SPEED_BITS{1'b1}};

    // configuration register indexes
    localparam logic CFG_TIMER_TOP   = 1'b0;
    localparam logic CFG_SPEED_SCALE = 1'b1;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIFF = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

endpackage

[hdl/tach_capture_speed.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tach_capture_speed
// Speed in 1/256 mph from the tick count between successive tach-edge
// captures: speed = speed_scale / ticks, clamped to the output range.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-----------------------------
//  in      | input     | i_in_valid / o_in_stall  | i_capture_value
//  out     | output    | o_out_valid / i_out_stall| o_speed_q8, o_measured,
//          |           |                          | o_saturated
//  cfg     | input     | i_cfg_wr_en              | i_cfg_index, i_cfg_wr_data
//
//  A measured item forms the tick difference, runs the bit-serial divider
//  (one quotient bit per cycle), then is handed off. Unmeasured items go
//  straight to the done state, or via the difference state on a zero tick
//  difference. Reset is synchronous and active low; it clears state and
//  loads the register defaults. The input is stalled while an item is in
//  work; a stalled output holds the next result in the sequencer.
//
module tach_capture_speed (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [tcs_pkg::CAPTURE_BITS-1:0]     i_capture_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [tcs_pkg::SPEED_BITS-1:0]       o_speed_q8,
    output logic                                 o_measured,
    output logic                                 o_saturated,
    input  logic                                 i_cfg_wr_en,
    input  logic                                 i_cfg_index,
    input  logic [tcs_pkg::SCALE_BITS-1:0]       i_cfg_wr_data
);

    tcs_pkg::t_state                     r_state;
    tcs_pkg::t_state                     n_state;

    logic [tcs_pkg::TIMER_BITS-1:0]      r_timer_top;
    logic [tcs_pkg::SCALE_BITS-1:0]      r_speed_scale;
    logic [tcs_pkg::TIMER_BITS-1:0]      r_prev;
    logic                                r_have_prev;
    logic [tcs_pkg::TIMER_BITS-1:0]      r_cap;

    logic [tcs_pkg::SPEED_BITS-1:0]      r_res_speed;
    logic                                r_res_meas;
    logic                                r_res_sat;

    logic                                r_out_valid;
    logic [tcs_pkg::SPEED_BITS-1:0]      r_out_speed;
    logic                                r_out_meas;
    logic                                r_out_sat;

    logic                                w_in_xfer;
    logic                                w_out_free;
    logic [tcs_pkg::TIMER_BITS-1:0]      w_diff;
    logic                                w_div_start;
    logic                                w_div_done;
    logic [tcs_pkg::SCALE_BITS-1:0]      w_quotient;
    logic                                w_sat;

    assign w_in_xfer  = i_in_valid && (r_state == tcs_pkg::S_IDLE);
    assign o_in_stall = (r_state != tcs_pkg::S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // tick difference, wrapping through the timer top
    always_comb begin
        if (r_cap >= r_prev) begin
            w_diff = r_cap - r_prev;
        end else begin
            w_diff = r_timer_top - r_prev + r_cap + 1'b1;
        end
    end

    assign w_div_start = (r_state == tcs_pkg::S_DIFF) && (w_diff != '0);
    assign w_sat       = |w_quotient[tcs_pkg::SCALE_BITS-1:tcs_pkg::SPEED_BITS];

    tcs_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_speed_scale),
        .i_divisor  (w_diff),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer_top   <= '1;
            r_speed_scale <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                tcs_pkg::CFG_TIMER_TOP:
                    r_timer_top <= i_cfg_wr_data[tcs_pkg::TIMER_BITS-1:0];
                tcs_pkg::CFG_SPEED_SCALE:
                    r_speed_scale <= i_cfg_wr_data;
                default: ;
            endcase
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tcs_pkg::S_IDLE: begin
                if (w_in_xfer) begin
                    if (r_speed_scale == '0 || !r_have_prev) begin
                        n_state = tcs_pkg::S_DONE;
                    end else begin
                        n_state = tcs_pkg::S_DIFF;
                    end
                end
            end
            tcs_pkg::S_DIFF: begin
                n_state = (w_diff == '0) ? tcs_pkg::S_DONE : tcs_pkg::S_DIV;
            end
            tcs_pkg::S_DIV: begin
                if (w_div_done) begin
                    n_state = tcs_pkg::S_DONE;
                end
            end
            tcs_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = tcs_pkg::S_IDLE;
                end
            end
            default: n_state = tcs_pkg::S_IDLE;
        endcase
    end

    // sequencer and capture history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcs_pkg::S_IDLE;
            r_prev      <= '0;
            r_have_prev <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_xfer && r_speed_scale != '0 && !r_have_prev) begin
                r_prev      <= i_capture_value[tcs_pkg::TIMER_BITS-1:0];
                r_have_prev <= 1'b1;
            end else if (r_state == tcs_pkg::S_DIFF) begin
                r_prev <= r_cap;
            end
        end
    end

    // pending result held by the sequencer
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_cap       <= i_capture_value[tcs_pkg::TIMER_BITS-1:0];
            r_res_speed <= '0;
            r_res_meas  <= 1'b0;
            r_res_sat   <= 1'b0;
        end else if (r_state == tcs_pkg::S_DIV && w_div_done) begin
            r_res_speed <= w_sat ? tcs_pkg::SPEED_MAX
                                 : w_quotient[tcs_pkg::SPEED_BITS-1:0];
            r_res_meas  <= 1'b1;
            r_res_sat   <= w_sat;
        end
    end

    // output register, loaded when the previous result has been taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == tcs_pkg::S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == tcs_pkg::S_DONE && w_out_free) begin
            r_out_speed <= r_res_speed;
            r_out_meas  <= r_res_meas;
            r_out_sat   <= r_res_sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_speed_q8  = r_out_speed;
    assign o_measured  = r_out_meas;
    assign o_saturated = r_out_sat;

    // an unmeasured result carries no speed and no clamp flag
    a_unmeasured_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_measured) |-> (o_speed_q8 == '0 && !o_saturated))
        else $error("unmeasured result with nonzero speed or clamp flag");

    // a clamped result sits at the top of the range
    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |-> (o_speed_q8 == tcs_pkg::SPEED_MAX))
        else $error("clamped result below full scale");

    // the divider only finishes while the sequencer waits for it
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == tcs_pkg::S_DIV))
        else $error("divider finished outside the divide state");

    // an input transfer closes the input until the item is finished
    a_stall_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input open right after a transfer");

endmodule

[hdl/tcs_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_divider
// Restoring bit-serial divider: one quotient bit per cycle, the dividend
// shifts out of the top of the quotient register as quotient bits shift in.
// ----------------------------------------------------------------------------
module tcs_divider (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [tcs_pkg::SCALE_BITS-1:0]       i_dividend,
    input  logic [tcs_pkg::TIMER_BITS-1:0]       i_divisor,
    output logic                                 o_done,
    output logic [tcs_pkg::SCALE_BITS-1:0]       o_quotient
);

    logic                               r_busy;
    logic                               r_done;
    logic [tcs_pkg::CNT_BITS-1:0]       r_count;
    logic [tcs_pkg::SCALE_BITS-1:0]     r_quo;
    logic [tcs_pkg::TIMER_BITS:0]       r_rem;
    logic [tcs_pkg::TIMER_BITS-1:0]     r_div;

    logic [tcs_pkg::TIMER_BITS:0]       n_trial;
    logic                               n_fits;

    // shift in the next dividend bit and try the subtract
    always_comb begin
        n_trial = {r_rem[tcs_pkg::TIMER_BITS-1:0], r_quo[tcs_pkg::SCALE_BITS-1]};
        n_fits  = (n_trial >= {1'b0, r_div});
    end

    // control: busy flag, bit counter, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_count <= '0;
            end else if (r_busy) begin
                if (r_count == tcs_pkg::CNT_BITS'(tcs_pkg::SCALE_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_count <= r_count + 1'b1;
            end
        end
    end

    // datapath: remainder and quotient shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[tcs_pkg::SCALE_BITS-2:0], n_fits};
            r_rem <= n_fits ? (n_trial - {1'b0, r_div}) : n_trial;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
